@@ rtl/ftqg_pkg.sv @@
// Shared constants, register indexes and types for the frame time quality governor
`default_nettype none

package ftqg_pkg;

  localparam int WINDOW_FRAMES_DEF    = 16;
  localparam int MAX_LEVEL_DEF        = 3;
  localparam int HALF_SCALE_LEVEL_DEF = 2;

  localparam int PERCENT_ONE   = 100;
  localparam int PERCENT_W     = 7;
  localparam int PERCENT_MAX   = 127;
  localparam int SAMPLE_W      = 32;
  localparam int SAMPLE_PCT_W  = SAMPLE_W + PERCENT_W;
  localparam int SLOW_NEED_W   = 5;
  localparam int WIN_CNT_W     = 8;
  localparam int BACKOFF_SHIFT = 1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_AUTO_ENABLE,
    CFG_FRAME_BUDGET,
    CFG_MAX_SAMPLE,
    CFG_SLOW_NEEDED,
    CFG_HEADROOM_PCT,
    CFG_BASE_RECOVERY,
    CFG_MAX_RECOVERY,
    CFG_PROBE_NEEDED
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SCALE_FULL,
    SCALE_HALF,
    SCALE_MIN
  } scale_t;

  typedef struct packed {
    logic                   auto_enable;
    logic [SAMPLE_W-1:0]    frame_budget_ns;
    logic [SAMPLE_W-1:0]    max_sample_ns;
    logic [SLOW_NEED_W-1:0] slow_frames_needed;
    logic [PERCENT_W-1:0]   headroom_percent;
    logic [WIN_CNT_W-1:0]   base_recovery_windows;
    logic [WIN_CNT_W-1:0]   max_recovery_windows;
    logic [WIN_CNT_W-1:0]   probe_windows_needed;
  } cfg_t;

  localparam logic                   RST_AUTO_ENABLE  = 1'b1;
  localparam logic [SAMPLE_W-1:0]    RST_FRAME_BUDGET = 32'd16666666;
  localparam logic [SAMPLE_W-1:0]    RST_MAX_SAMPLE   = 32'd100000000;
  localparam logic [SLOW_NEED_W-1:0] RST_SLOW_NEEDED  = 5'd4;
  localparam logic [PERCENT_W-1:0]   RST_HEADROOM_PCT = 7'd70;
  localparam logic [WIN_CNT_W-1:0]   RST_BASE_RECOVERY = 8'd2;
  localparam logic [WIN_CNT_W-1:0]   RST_MAX_RECOVERY = 8'd32;
  localparam logic [WIN_CNT_W-1:0]   RST_PROBE_NEEDED = 8'd4;

endpackage

`default_nettype wire

@@ rtl/ftqg_cfg.sv @@
// Configuration registers and the derived window thresholds
`default_nettype none

module ftqg_cfg #(
  parameter int WINDOW_FRAMES = ftqg_pkg::WINDOW_FRAMES_DEF,
  parameter int TH_W          = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [ftqg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [ftqg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output ftqg_pkg::cfg_t                          cfg,
  output logic [TH_W-1:0]                         budget_pct,
  output logic [TH_W-1:0]                         room_pct
);

  localparam int WP_W    = $clog2(WINDOW_FRAMES * ftqg_pkg::PERCENT_MAX + 1);
  localparam int BUD_MUL = WINDOW_FRAMES * ftqg_pkg::PERCENT_ONE;

  ftqg_pkg::cfg_t    cfg_r;
  logic [WP_W-1:0]   win_pct_r;
  logic [TH_W-1:0]   budget_pct_r;
  logic [TH_W-1:0]   room_pct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_enable           <= ftqg_pkg::RST_AUTO_ENABLE;
      cfg_r.frame_budget_ns       <= ftqg_pkg::RST_FRAME_BUDGET;
      cfg_r.max_sample_ns         <= ftqg_pkg::RST_MAX_SAMPLE;
      cfg_r.slow_frames_needed    <= ftqg_pkg::RST_SLOW_NEEDED;
      cfg_r.headroom_percent      <= ftqg_pkg::RST_HEADROOM_PCT;
      cfg_r.base_recovery_windows <= ftqg_pkg::RST_BASE_RECOVERY;
      cfg_r.max_recovery_windows  <= ftqg_pkg::RST_MAX_RECOVERY;
      cfg_r.probe_windows_needed  <= ftqg_pkg::RST_PROBE_NEEDED;
      win_pct_r <= WP_W'(WINDOW_FRAMES) * WP_W'(ftqg_pkg::RST_HEADROOM_PCT);
    end else if (cfg_we) begin
      unique case (ftqg_pkg::cfg_idx_t'(cfg_index))
        ftqg_pkg::CFG_AUTO_ENABLE:   cfg_r.auto_enable <= cfg_wdata[0];
        ftqg_pkg::CFG_FRAME_BUDGET:  cfg_r.frame_budget_ns <= cfg_wdata;
        ftqg_pkg::CFG_MAX_SAMPLE:    cfg_r.max_sample_ns <= cfg_wdata;
        ftqg_pkg::CFG_SLOW_NEEDED:
          cfg_r.slow_frames_needed <= cfg_wdata[ftqg_pkg::SLOW_NEED_W-1:0];
        ftqg_pkg::CFG_HEADROOM_PCT: begin
          cfg_r.headroom_percent <= cfg_wdata[ftqg_pkg::PERCENT_W-1:0];
          win_pct_r <= WP_W'(WINDOW_FRAMES) * WP_W'(cfg_wdata[ftqg_pkg::PERCENT_W-1:0]);
        end
        ftqg_pkg::CFG_BASE_RECOVERY:
          cfg_r.base_recovery_windows <= cfg_wdata[ftqg_pkg::WIN_CNT_W-1:0];
        ftqg_pkg::CFG_MAX_RECOVERY:
          cfg_r.max_recovery_windows <= cfg_wdata[ftqg_pkg::WIN_CNT_W-1:0];
        ftqg_pkg::CFG_PROBE_NEEDED:
          cfg_r.probe_windows_needed <= cfg_wdata[ftqg_pkg::WIN_CNT_W-1:0];
      endcase
    end
  end

  // thresholds are kept scaled by the percent base so no division is needed
  always_ff @(posedge clk) begin
    budget_pct_r <= TH_W'(cfg_r.frame_budget_ns) * TH_W'(BUD_MUL);
    room_pct_r   <= TH_W'(cfg_r.frame_budget_ns) * TH_W'(win_pct_r);
  end

  assign cfg        = cfg_r;
  assign budget_pct = budget_pct_r;
  assign room_pct   = room_pct_r;

endmodule

`default_nettype wire

@@ rtl/frame_time_quality_governor.sv @@
// A word taken into the input register passes the window update into the result register.
// Throughput: one word per cycle while out_stall does not hold the result word; the input
// register and the window update after it advance together under out_stall.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// window, the level and the probe, and sets the recovery wait to its floor.
// Thresholds follow a budget or percent write via the configuration and threshold registers.
`default_nettype none

module frame_time_quality_governor #(
  parameter int WINDOW_FRAMES    = ftqg_pkg::WINDOW_FRAMES_DEF,
  parameter int MAX_LEVEL        = ftqg_pkg::MAX_LEVEL_DEF,
  parameter int HALF_SCALE_LEVEL = ftqg_pkg::HALF_SCALE_LEVEL_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ftqg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ftqg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [31:0]                      in_frame_time_ns,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            out_quality_level,
  output logic [1:0]                            out_scale_code,
  output logic                                  out_window_closed,
  output logic                                  out_sample_ignored
);

  localparam int LVL_W  = $clog2(MAX_LEVEL + 1);
  localparam int CNT_W  = $clog2(WINDOW_FRAMES);
  localparam int CNT1_W = CNT_W + 1;
  localparam int SLOW_W = $clog2(WINDOW_FRAMES + 1);
  localparam int CMP_W  = (SLOW_W > ftqg_pkg::SLOW_NEED_W) ? SLOW_W : ftqg_pkg::SLOW_NEED_W;
  localparam int TH_W   = ftqg_pkg::SAMPLE_W
                          + $clog2(WINDOW_FRAMES * ftqg_pkg::PERCENT_MAX + 1);
  localparam int WC_W   = ftqg_pkg::WIN_CNT_W;
  localparam int HL_W   = 4;

  ftqg_pkg::cfg_t    cfg;
  logic [TH_W-1:0]   budget_pct;
  logic [TH_W-1:0]   room_pct;

  ftqg_cfg #(
    .WINDOW_FRAMES (WINDOW_FRAMES),
    .TH_W          (TH_W)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cfg        (cfg),
    .budget_pct (budget_pct),
    .room_pct   (room_pct)
  );

  logic                              adv_out;
  logic                              s1_go;
  logic                              in_take;
  logic                              s1_valid_r;
  logic [ftqg_pkg::SAMPLE_PCT_W-1:0] s1_tpct_r;
  logic                              s1_slow_r;
  logic                              s1_ign_r;
  logic [ftqg_pkg::SAMPLE_W-1:0]     t_clamp;

  assign adv_out  = !out_valid || !out_stall;
  assign s1_go    = s1_valid_r && adv_out;
  assign in_stall = s1_valid_r && !adv_out;
  assign in_take  = in_valid && !in_stall;
  assign t_clamp  = (in_frame_time_ns > cfg.max_sample_ns) ? cfg.max_sample_ns
                                                            : in_frame_time_ns;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv_out) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_tpct_r <= ftqg_pkg::SAMPLE_PCT_W'(t_clamp)
                   * ftqg_pkg::SAMPLE_PCT_W'(ftqg_pkg::PERCENT_ONE);
      s1_slow_r <= t_clamp > cfg.frame_budget_ns;
      s1_ign_r  <= !cfg.auto_enable || (in_frame_time_ns == '0);
    end
  end

  logic [TH_W-1:0]   acc_r, acc_nxt, acc_sum;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT1_W-1:0] cnt_sum;
  logic [SLOW_W-1:0] slow_r, slow_nxt, slow_sum;
  logic [LVL_W-1:0]  level_r, level_nxt;
  logic [WC_W-1:0]   hr_r, hr_nxt, hr_inc;
  logic [WC_W-1:0]   wait_r, wait_nxt, wait_flr, wait_half;
  logic [WC_W:0]     wait_dbl;
  logic              pa_r, pa_nxt;
  logic [WC_W-1:0]   pr_r, pr_nxt, pr_inc;
  logic              closed;
  logic              overload;
  logic              headroom;

  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    slow_nxt  = slow_r;
    level_nxt = level_r;
    hr_nxt    = hr_r;
    wait_nxt  = wait_r;
    pa_nxt    = pa_r;
    pr_nxt    = pr_r;
    closed    = 1'b0;
    wait_flr  = (wait_r < cfg.base_recovery_windows) ? cfg.base_recovery_windows : wait_r;
    wait_dbl  = {wait_flr, 1'b0};
    wait_half = wait_flr >> ftqg_pkg::BACKOFF_SHIFT;
    acc_sum   = acc_r + TH_W'(s1_tpct_r);
    cnt_sum   = CNT1_W'(cnt_r) + CNT1_W'(1);
    slow_sum  = slow_r + SLOW_W'(s1_slow_r);
    pr_inc    = pr_r + WC_W'(1);
    hr_inc    = hr_r + WC_W'(1);
    overload  = (acc_sum > budget_pct)
                && (CMP_W'(slow_sum) >= CMP_W'(cfg.slow_frames_needed));
    headroom  = (slow_sum == '0) && (acc_sum <= room_pct);
    if (!s1_ign_r) begin
      wait_nxt = wait_flr;
      if (cnt_sum == CNT1_W'(WINDOW_FRAMES)) begin
        closed   = 1'b1;
        acc_nxt  = '0;
        cnt_nxt  = '0;
        slow_nxt = '0;
        priority if (overload) begin
          if (level_r != LVL_W'(MAX_LEVEL)) begin
            level_nxt = level_r + LVL_W'(1);
          end
          hr_nxt = '0;
          if (pa_r) begin
            wait_nxt = (wait_dbl > {1'b0, cfg.max_recovery_windows})
                       ? cfg.max_recovery_windows : wait_dbl[WC_W-1:0];
          end
          pa_nxt = 1'b0;
          pr_nxt = '0;
        end else if (headroom) begin
          if (pa_r) begin
            if (pr_inc >= cfg.probe_windows_needed) begin
              pa_nxt   = 1'b0;
              pr_nxt   = '0;
              wait_nxt = (wait_half < cfg.base_recovery_windows)
                         ? cfg.base_recovery_windows : wait_half;
            end else begin
              pr_nxt = pr_inc;
            end
          end
          if (level_r != '0) begin
            if (hr_inc >= wait_nxt) begin
              level_nxt = level_r - LVL_W'(1);
              hr_nxt    = '0;
              pa_nxt    = 1'b1;
              pr_nxt    = '0;
            end else begin
              hr_nxt = hr_inc;
            end
          end
        end else begin
          hr_nxt = '0;
          pr_nxt = '0;
        end
      end else begin
        acc_nxt  = acc_sum;
        cnt_nxt  = CNT_W'(cnt_sum);
        slow_nxt = slow_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      cnt_r   <= '0;
      slow_r  <= '0;
      level_r <= '0;
      hr_r    <= '0;
      wait_r  <= ftqg_pkg::RST_BASE_RECOVERY;
      pa_r    <= 1'b0;
      pr_r    <= '0;
    end else if (s1_go) begin
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      slow_r  <= slow_nxt;
      level_r <= level_nxt;
      hr_r    <= hr_nxt;
      wait_r  <= wait_nxt;
      pa_r    <= pa_nxt;
      pr_r    <= pr_nxt;
    end
  end

  ftqg_pkg::scale_t scale_nxt;
  logic [HL_W-1:0]  level_cmp;

  always_comb begin
    level_cmp = HL_W'(level_nxt);
    priority if (level_cmp < HL_W'(HALF_SCALE_LEVEL)) begin
      scale_nxt = ftqg_pkg::SCALE_FULL;
    end else if (level_cmp == HL_W'(HALF_SCALE_LEVEL)) begin
      scale_nxt = ftqg_pkg::SCALE_HALF;
    end else begin
      scale_nxt = ftqg_pkg::SCALE_MIN;
    end
  end

  logic             out_valid_r;
  logic [1:0]       out_level_r;
  ftqg_pkg::scale_t out_scale_r;
  logic             out_closed_r;
  logic             out_ign_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_level_r  <= 2'(level_nxt);
      out_scale_r  <= scale_nxt;
      out_closed_r <= closed;
      out_ign_r    <= s1_ign_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quality_level  = out_level_r;
  assign out_scale_code     = out_scale_r;
  assign out_window_closed  = out_closed_r;
  assign out_sample_ignored = out_ign_r;

endmodule

`default_nettype wire

@@ rtl/ftqg_checker.sv @@
// Port-level checks for the frame time quality governor, bound to the top level
`default_nettype none

module ftqg_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_quality_level,
  input wire logic [1:0] out_scale_code,
  input wire logic       out_window_closed,
  input wire logic       out_sample_ignored
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_quality_level)
      && $stable(out_scale_code) && $stable(out_window_closed)
      && $stable(out_sample_ignored))
    else $error("stalled result word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

  a_closed_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_closed |-> !out_sample_ignored)
    else $error("ignored word closed a window");

  a_scale_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_scale_code != 2'd3)
    else $error("scale code out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result valid after reset");

endmodule

bind frame_time_quality_governor ftqg_checker u_ftqg_checker (.*);

`default_nettype wire
